// ----- hdl/csn_pkg.sv -----
// Shared types and constants for the color sensor normalizer.
// No dependencies; compile first.
`default_nettype none

package csn_pkg;

    // Quotient bits kept by the divider. A ratio of 1023 or more already
    // clamps to 255 after every correction, so larger ratios saturate.
    localparam int QBITS = 10;

    // Pipeline depth: QBITS divide stages, one scale stage, one merge stage.
    localparam int NSTG = QBITS + 2;

    // floor(x / 3) == (x * 2731) >> 13 for x < 8192; used as floor(2t/3).
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 12;

    localparam int LEVEL_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DARK_CLEAR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_CLEAR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_CLEAR  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPREAD       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET       = 3'd5;

    // Reset values
    localparam logic [15:0] DARK_CLEAR_RST   = 16'd250;
    localparam logic [15:0] BRIGHT_CLEAR_RST = 16'd650;
    localparam logic [15:0] WHITE_CLEAR_RST  = 16'd800;
    localparam logic [7:0]  BLACK_LEVEL_RST  = 8'd60;
    localparam logic [7:0]  SPREAD_RST       = 8'd40;
    localparam logic [7:0]  OFFSET_RST       = 8'd40;

    // Scene classification of one sample, carried down the pipeline
    typedef struct packed {
        logic zero;    // clear count is zero
        logic dark;    // clear below dark limit
        logic bright;  // clear above bright limit
        logic full;    // clear at full scale
        logic white;   // clear above white limit
    } csn_flags_t;

endpackage

`default_nettype wire

// ----- hdl/csn_ifs.sv -----
// Valid/ready channel interfaces for the color sensor normalizer.
// No dependencies besides the parameter given at instantiation.
`default_nettype none

interface csn_in_if #(parameter int CHANNEL_BITS = 16);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] clear_in;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;

    modport source (output valid, clear_in, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, clear_in, red_in, green_in, blue_in, output ready);
endinterface

interface csn_out_if #(parameter int CHANNEL_BITS = 16);
    logic                    valid;
    logic                    ready;
    logic [7:0]              red_out;
    logic [7:0]              green_out;
    logic [7:0]              blue_out;
    logic [CHANNEL_BITS-1:0] clear_out;

    modport source (output valid, red_out, green_out, blue_out, clear_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, clear_out, output ready);
endinterface

interface csn_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/csn_lane.sv -----
// One color lane: pipelined restoring divider (x*256/clear) and scene scaling.
// Depends on csn_pkg.
`default_nettype none

module csn_lane #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                     clk,
    input  logic [csn_pkg::QBITS:0]  en,
    input  logic [CHANNEL_BITS-1:0]  raw,
    input  logic [CHANNEL_BITS-1:0]  den [csn_pkg::QBITS],
    input  csn_pkg::csn_flags_t      flg,
    input  logic [7:0]               offset,
    output logic [7:0]               level
);
    import csn_pkg::*;

    localparam int VW = QBITS;        // saturated ratio width
    localparam int TW = QBITS + 3;    // signed working width
    localparam int PW = 2 * (TW - 1); // reciprocal product width

    logic [CHANNEL_BITS-1:0] rem_reg [QBITS];
    logic [QBITS-1:0]        quo_reg [QBITS];
    logic                    sat_reg [QBITS];
    logic                    lsb_reg;

    logic [CHANNEL_BITS-1:0] rem_in [QBITS];
    logic                    nbit   [QBITS];
    logic [QBITS-1:0]        quo_in [QBITS];
    logic                    sat_in [QBITS];
    logic                    sat0;

    // ratio of 1024 or more when raw >= 4*clear
    assign sat0 = ({2'b00, raw} >= {den[0], 2'b00});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lsb_reg <= raw[0];
        end
    end

    for (genvar s = 0; s < QBITS; s++)
    begin : g_div
        logic [CHANNEL_BITS:0]   shv;
        logic [CHANNEL_BITS:0]   dif;
        logic                    qb;

        if (s == 0)
        begin : g_first
            assign rem_in[s] = raw >> 2;
            assign nbit[s]   = raw[1];
            assign quo_in[s] = '0;
            assign sat_in[s] = sat0;
        end
        else
        begin : g_rest
            assign rem_in[s] = rem_reg[s-1];
            assign nbit[s]   = (s == 1) ? lsb_reg : 1'b0;
            assign quo_in[s] = quo_reg[s-1];
            assign sat_in[s] = sat_reg[s-1];
        end

        assign shv = {rem_in[s], nbit[s]};
        assign dif = shv - {1'b0, den[s]};
        assign qb  = ~dif[CHANNEL_BITS];

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= qb ? dif[CHANNEL_BITS-1:0] : shv[CHANNEL_BITS-1:0];
                quo_reg[s] <= {quo_in[s][QBITS-2:0], qb};
                sat_reg[s] <= sat_in[s];
            end
        end
    end

    // Scale stage
    logic [VW-1:0]        v;
    logic signed [TW-1:0] d;
    logic signed [TW-1:0] t;
    logic [PW-1:0]        prod;
    logic [VW:0]          sum;
    logic [VW+1:0]        ks;
    logic [VW+3:0]        m3;
    logic [VW:0]          nv;
    logic [VW+2:0]        mag;
    logic [7:0]           level_reg;
    logic [7:0]           level_next;

    assign v    = sat_reg[QBITS-1] ? '1 : quo_reg[QBITS-1];
    assign d    = $signed({3'b000, v}) - $signed({{(TW-8){1'b0}}, offset});
    assign t    = flg.full ? (d <<< 1) : d;
    assign prod = {{(PW-TW+1){1'b0}}, t[TW-2:0]} * PW'(DIV3_MUL);
    assign sum  = {1'b0, v} + {{(VW-7){1'b0}}, offset};
    assign ks   = flg.full ? {sum, 1'b0} : {1'b0, sum};
    assign m3   = {2'b00, ks} + {1'b0, ks, 1'b0};
    assign nv   = flg.full ? {v, 1'b0} : {1'b0, v};

    always_comb
    begin
        if (flg.dark)
        begin
            if (t > 0)
            begin
                mag = (VW+3)'(prod[PW-1:DIV3_SHIFT]);
            end
            else
            begin
                mag = '0;
            end
        end
        else if (flg.bright)
        begin
            mag = m3[VW+3:1];
        end
        else
        begin
            mag = {2'b00, nv};
        end
        level_next = (mag > (VW+3)'(255)) ? 8'hFF : mag[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[QBITS])
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

// ----- hdl/csn_merge.sv -----
// Merge stage: grey test over the three lanes, white/black forcing, output register.
// Depends on csn_pkg.
`default_nettype none

module csn_merge (
    input  logic                clk,
    input  logic                en,
    input  logic [7:0]          level [3],
    input  csn_pkg::csn_flags_t flg,
    input  logic [7:0]          spread,
    input  logic [7:0]          black,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue
);
    import csn_pkg::*;

    logic [7:0] hi;
    logic [7:0] lo;
    logic       grey;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic [7:0] red_next, green_next, blue_next;

    always_comb
    begin
        hi = level[0];
        lo = level[0];
        for (int i = 1; i < 3; i++)
        begin
            if (level[i] > hi)
            begin
                hi = level[i];
            end
            if (level[i] < lo)
            begin
                lo = level[i];
            end
        end
        grey = ((hi - lo) <= spread);

        red_next   = level[0];
        green_next = level[1];
        blue_next  = level[2];
        if (flg.zero)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
        else if (grey && flg.white)
        begin
            red_next   = 8'hFF;
            green_next = 8'hFF;
            blue_next  = 8'hFF;
        end
        else if (grey && (hi < black) && flg.dark)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

// ----- hdl/color_sensor_normalizer.sv -----
// Color sensor normalizer top level: config registers, control pipeline, three lanes, merge.
// Pipeline from input transfer to output register: the divide stages, then the scale
// stage, then the merge stage.
// Throughput: one sample per cycle; each stage holds only while its successor is full.
// The per-lane divider retires one quotient bit per stage, which sets the depth.
// Reset (rst_n low, asynchronous): pipeline emptied, config registers to defaults.
// Depends on csn_pkg, csn_ifs, csn_lane, csn_merge.
`default_nettype none

module color_sensor_normalizer #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    csn_in_if.sink    sample,
    csn_out_if.source color,
    csn_cfg_if.sink   cfg
);
    import csn_pkg::*;

    // common width for comparing clear against the 16-bit limits
    localparam int CW = (CHANNEL_BITS > CFG_DATA_BITS) ? CHANNEL_BITS : CFG_DATA_BITS;

    // ---------------------------------------------------------------
    // Configuration registers: always ready, unknown indexes dropped
    // ---------------------------------------------------------------
    logic [15:0] dark_lim_reg;
    logic [15:0] bright_lim_reg;
    logic [15:0] white_lim_reg;
    logic [7:0]  black_lim_reg;
    logic [7:0]  spread_reg;
    logic [7:0]  offset_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_lim_reg   <= DARK_CLEAR_RST;
            bright_lim_reg <= BRIGHT_CLEAR_RST;
            white_lim_reg  <= WHITE_CLEAR_RST;
            black_lim_reg  <= BLACK_LEVEL_RST;
            spread_reg     <= SPREAD_RST;
            offset_reg     <= OFFSET_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DARK_CLEAR:   dark_lim_reg   <= cfg.data;
                REG_BRIGHT_CLEAR: bright_lim_reg <= cfg.data;
                REG_WHITE_CLEAR:  white_lim_reg  <= cfg.data;
                REG_BLACK_LEVEL:  black_lim_reg  <= cfg.data[7:0];
                REG_SPREAD:       spread_reg     <= cfg.data[7:0];
                REG_OFFSET:       offset_reg     <= cfg.data[7:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage enables: a stage advances when it is empty or its successor
    // advances, so bubbles collapse and input keeps flowing while a
    // finished result waits in the output register, until every stage is full.
    // ---------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = ~vld_reg[NSTG-1] | color.ready;
        for (int s = NSTG - 2; s >= 0; s--)
        begin
            en[s] = ~vld_reg[s] | en[s+1];
        end
        for (int s = 0; s < NSTG; s++)
        begin
            if (en[s])
            begin
                vld_next[s] = (s == 0) ? sample.valid : vld_reg[(s == 0) ? 0 : s - 1];
            end
            else
            begin
                vld_next[s] = vld_reg[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign sample.ready = en[0];

    // ---------------------------------------------------------------
    // Scene classification at entry; flags and clear ride alongside
    // ---------------------------------------------------------------
    logic [CW-1:0] clr_x;
    csn_flags_t    flg_in;
    csn_flags_t    flg_reg [QBITS+1];
    logic [CHANNEL_BITS-1:0] clr_reg [NSTG];
    logic [CHANNEL_BITS-1:0] den [QBITS];

    assign clr_x         = CW'(sample.clear_in);
    assign flg_in.zero   = (sample.clear_in == '0);
    assign flg_in.dark   = (clr_x < CW'(dark_lim_reg));
    assign flg_in.bright = (clr_x > CW'(bright_lim_reg));
    assign flg_in.full   = &sample.clear_in;
    assign flg_in.white  = (clr_x > CW'(white_lim_reg));

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NSTG; s++)
        begin
            if (en[s])
            begin
                clr_reg[s] <= (s == 0) ? sample.clear_in : clr_reg[(s == 0) ? 0 : s - 1];
            end
        end
        for (int s = 0; s <= QBITS; s++)
        begin
            if (en[s])
            begin
                flg_reg[s] <= (s == 0) ? flg_in : flg_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // divisor seen by each divide stage
    always_comb
    begin
        den[0] = sample.clear_in;
        for (int s = 1; s < QBITS; s++)
        begin
            den[s] = clr_reg[s-1];
        end
    end

    // ---------------------------------------------------------------
    // Lanes: red, green, blue
    // ---------------------------------------------------------------
    logic [7:0] level [3];

    csn_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_red (
        .clk    (clk),
        .en     (en[QBITS:0]),
        .raw    (sample.red_in),
        .den    (den),
        .flg    (flg_reg[QBITS-1]),
        .offset (offset_reg),
        .level  (level[0])
    );

    csn_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_green (
        .clk    (clk),
        .en     (en[QBITS:0]),
        .raw    (sample.green_in),
        .den    (den),
        .flg    (flg_reg[QBITS-1]),
        .offset (offset_reg),
        .level  (level[1])
    );

    csn_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_blue (
        .clk    (clk),
        .en     (en[QBITS:0]),
        .raw    (sample.blue_in),
        .den    (den),
        .flg    (flg_reg[QBITS-1]),
        .offset (offset_reg),
        .level  (level[2])
    );

    // ---------------------------------------------------------------
    // Merge and output register
    // ---------------------------------------------------------------
    csn_merge u_merge (
        .clk    (clk),
        .en     (en[NSTG-1]),
        .level  (level),
        .flg    (flg_reg[QBITS]),
        .spread (spread_reg),
        .black  (black_lim_reg),
        .red    (color.red_out),
        .green  (color.green_out),
        .blue   (color.blue_out)
    );

    assign color.valid     = vld_reg[NSTG-1];
    assign color.clear_out = clr_reg[NSTG-1];

`ifndef SYNTH
    // an accepted sample occupies the first stage next cycle
    a_entry_fill: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> vld_reg[0])
        else $error("accepted sample missing from first stage");

    // input stalls only when every stage is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> &vld_reg)
        else $error("input stalled with a bubble in the pipeline");

    // zero clear gives black
    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid && (color.clear_out == '0) |->
            (color.red_out == 8'd0) && (color.green_out == 8'd0) && (color.blue_out == 8'd0))
        else $error("nonzero color with zero clear");
`endif

endmodule

`default_nettype wire
